[rtl/core/mrf_pkg.sv]
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and constants for the Modbus RTU request framer
// Function codes, status codes, the CRC-16/MODBUS byte update and the
// request word layout used by the framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

  // Modbus function codes
  localparam logic [7:0] FC_READ_COILS       = 8'd1;
  localparam logic [7:0] FC_WRITE_SINGLE_REG = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI_COIL = 8'd15;
  localparam logic [7:0] FC_WRITE_MULTI_REG  = 8'd16;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UNSUP   = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  // CRC-16/MODBUS, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] STATION_RESET = 8'd1;

  typedef struct packed {
    logic [15:0] payload;
    logic [15:0] reg_addr;
    logic [7:0]  operation;
  } req_t;

  // Fold one byte into the running CRC, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/modbus_rtu_request_framer.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer: Modbus RTU master request framer
// Turns one request word into the 8-byte RTU frame with CRC-16/MODBUS,
// one byte per output word, or into a single flagged error word.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+-----------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: operation, reg_addr, payload
//  out_    | out | out_tvalid/tready  | tdata: frame_byte, tlast, tuser: status
//  cfg_    | in  | cfg_valid/ready    | cfg_data: station_address
//
//  A valid request yields 8 output words, one per cycle while out_tready
//  is high; an error request yields one. The byte serializer loads one
//  byte a cycle into the output register unless the output stalls.
//  The next request is taken in the cycle its predecessor's last byte is
//  loaded, so frames stream back to back with no gap.
//  Reset (rst_n low, synchronous) empties both stages and sets the station
//  to 1. A stalled output holds its word and freezes the serializer.
//
module modbus_rtu_request_framer (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] operation, [23:8] reg_addr,
                                  // [39:24] payload

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast,  // last_byte
  output logic [1:0]  out_tuser,  // [1:0] status

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // station_address
);

  localparam logic [mrf_pkg::POS_W-1:0] POS_LAST =
    mrf_pkg::POS_W'(mrf_pkg::FRAME_BYTES - 1);

  // Station register
  logic [7:0] station_r;

  // Request stage
  logic                       req_vld_r;
  mrf_pkg::req_t              req_r;
  logic [mrf_pkg::POS_W-1:0]  pos_r;
  logic [15:0]                crc_r;

  // Output stage
  logic        out_vld_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic [1:0]  out_status_r;

  // Serializer controls
  logic                       out_load;
  logic                       req_ok;
  logic                       req_done;
  logic                       in_take;
  logic [15:0]                crc_base;
  logic [15:0]                crc_nxt;
  logic [7:0]                 byte_nxt;
  logic [1:0]                 status_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= mrf_pkg::STATION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      station_r <= cfg_data;
    end
  end

  // Load a new output word while a request is held and the output register is empty or drains.
  assign out_load = req_vld_r && (!out_vld_r || out_tready);

  assign req_ok = (req_r.operation >= mrf_pkg::FC_READ_COILS) &&
                  (req_r.operation <= mrf_pkg::FC_WRITE_SINGLE_REG);

  // An error request is done after one word, a frame after its last byte.
  assign req_done  = out_load && (!req_ok || (pos_r == POS_LAST));
  assign in_tready = !req_vld_r || req_done;
  assign in_take   = in_tvalid && in_tready;

  // Restart the CRC at the first byte of each frame.
  assign crc_base = (pos_r == '0) ? mrf_pkg::CRC_INIT : crc_r;

  always_comb begin
    unique case (pos_r)
      3'd0:    byte_nxt = station_r;
      3'd1:    byte_nxt = req_r.operation;
      3'd2:    byte_nxt = req_r.reg_addr[15:8];
      3'd3:    byte_nxt = req_r.reg_addr[7:0];
      3'd4:    byte_nxt = req_r.payload[15:8];
      3'd5:    byte_nxt = req_r.payload[7:0];
      3'd6:    byte_nxt = crc_r[7:0];
      default: byte_nxt = crc_r[15:8];
    endcase
  end

  assign crc_nxt = mrf_pkg::crc_byte(crc_base, byte_nxt);

  always_comb begin
    priority if (req_ok) begin
      status_nxt = mrf_pkg::STATUS_OK;
    end else if (req_r.operation == mrf_pkg::FC_WRITE_MULTI_COIL ||
                 req_r.operation == mrf_pkg::FC_WRITE_MULTI_REG) begin
      status_nxt = mrf_pkg::STATUS_UNSUP;
    end else begin
      status_nxt = mrf_pkg::STATUS_UNKNOWN;
    end
  end

  // Request stage: hold the request while its bytes go out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      pos_r     <= '0;
    end else begin
      if (in_take) begin
        req_vld_r <= 1'b1;
      end else if (req_done) begin
        req_vld_r <= 1'b0;
      end
      if (req_done) begin
        pos_r <= '0;
      end else if (out_load) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r <= mrf_pkg::req_t'(in_tdata);
    end
    // Fold only the six header bytes into the CRC; hold it for the tail.
    if (out_load && req_ok && (pos_r < 3'd6)) begin
      crc_r <= crc_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r   <= req_ok ? byte_nxt : 8'h00;
      out_last_r   <= !req_ok || (pos_r == POS_LAST);
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != mrf_pkg::STATUS_OK) |-> out_tlast && (out_tdata == 8'h00))
    else $error("error word without tlast or with nonzero byte");

  a_pos_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0) |-> req_vld_r)
    else $error("byte position advanced without a request");

  a_take_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && req_vld_r |-> req_done)
    else $error("request overwritten before its last word");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && req_ok && (pos_r == POS_LAST) |=> out_tvalid && out_tlast)
    else $error("final frame byte not marked last");

  a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && req_ok && (pos_r != POS_LAST) |=> !out_tlast)
    else $error("tlast on a middle frame byte");

endmodule
